// ===== design/switch_press_classifier_assert.svh =====
// assertion macros for the switch press classifier checker
`ifndef SWITCH_PRESS_CLASSIFIER_ASSERT_SVH
`define SWITCH_PRESS_CLASSIFIER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spc check failed: same-cycle rule");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spc check failed: next-cycle rule");

`endif

// ===== design/spc_pkg.sv =====
// shared constants and types for the switch press classifier
`timescale 1ns / 1ps

package spc_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned EVENT_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [TIME_W-1:0]    time_ms_t;
  typedef logic [EVENT_W-1:0]   event_code_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // result event codes
  localparam event_code_t EV_NONE  = 2'd0;
  localparam event_code_t EV_FIRST = 2'd1;
  localparam event_code_t EV_LONG  = 2'd2;
  localparam event_code_t EV_SHORT = 2'd3;

  // register indexes
  localparam cfg_idx_t CFG_STARTUP_WINDOW = 2'd0;
  localparam cfg_idx_t CFG_FIRST_HOLD     = 2'd1;
  localparam cfg_idx_t CFG_LONG_PRESS     = 2'd2;

  // register reset values
  localparam time_ms_t STARTUP_WINDOW_RST = 32'd2000;
  localparam time_ms_t FIRST_HOLD_RST     = 32'd50;
  localparam time_ms_t LONG_PRESS_RST     = 32'd1000;

endpackage

// ===== design/spc_if.sv =====
// valid/ready channel interfaces for the switch press classifier
`timescale 1ns / 1ps

interface spc_in_if
  import spc_pkg::*;
();
  logic     valid;
  logic     ready;
  logic     pressed;
  time_ms_t now_ms;

  modport source (output valid, output pressed, output now_ms, input ready);
  modport sink   (input valid, input pressed, input now_ms, output ready);
endinterface

interface spc_out_if
  import spc_pkg::*;
();
  logic        valid;
  logic        ready;
  event_code_t event_res;
  logic        hold_latch;
  logic        startup_done;
  logic        first_pending;

  modport source (output valid, output event_res, output hold_latch, output startup_done,
                  output first_pending, input ready);
  modport sink   (input valid, input event_res, input hold_latch, input startup_done,
                  input first_pending, output ready);
endinterface

// ===== design/switch_press_classifier.sv =====
// switch press classifier top level: first, long and short press events
`timescale 1ns / 1ps
//
//  channel  dir  beat contents                                   handshake
//  in_ch    in   pressed, now_ms                                 valid/ready
//  out_ch   out  event_res, hold_latch, startup_done, first_pending valid/ready
//  cfg_*    in   cfg_idx, cfg_wdata                              cfg_we, no wait
//
//  one input beat per cycle while out_ch is ready; each beat gives one result
//  beat (input register, then classify into result register)
//  the per-beat path is one 32-bit held-time subtract and three 32-bit compares
//  rst_n is synchronous, active low: clears press state, flags and both stages
//  a stalled result holds the result register; the input register still takes a
//  beat, so the input side stops only when both stages are full

module switch_press_classifier
  import spc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  spc_in_if.sink     in_ch,
  spc_out_if.source  out_ch,
  input  logic       cfg_we,
  input  cfg_idx_t   cfg_idx,
  input  time_ms_t   cfg_wdata
);

  // configuration registers
  time_ms_t startup_window_r;
  time_ms_t first_hold_r;
  time_ms_t long_press_r;

  // input stage
  logic     s1_valid_r;
  logic     s1_pressed_r;
  time_ms_t s1_now_r;

  // press tracking state
  logic     startup_over_r;
  logic     first_latched_r;
  logic     first_in_prog_r;
  logic     press_on_r;
  time_ms_t press_start_r;
  logic     long_supp_r;
  logic     long_sent_r;

  // result stage
  logic        out_valid_r;
  event_code_t out_event_r;
  logic        out_latch_r;
  logic        out_startup_r;
  logic        out_pending_r;

  // next values from the classify logic
  logic        startup_over_nxt;
  logic        first_latched_nxt;
  logic        first_in_prog_nxt;
  logic        press_on_nxt;
  time_ms_t    press_start_nxt;
  logic        long_supp_nxt;
  logic        long_sent_nxt;
  event_code_t event_nxt;

  logic     advance;
  logic     press_begin;
  time_ms_t held;

  // stage 1 moves into the result register when the result slot is free
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.event_res     = out_event_r;
  assign out_ch.hold_latch    = out_latch_r;
  assign out_ch.startup_done  = out_startup_r;
  assign out_ch.first_pending = out_pending_r;

  always_comb begin
    startup_over_nxt  = startup_over_r || (s1_now_r >= startup_window_r);
    press_begin       = s1_pressed_r && !press_on_r;

    // a new press restarts the timer and decides if it is the first press
    press_start_nxt   = press_begin ? s1_now_r : press_start_r;
    long_supp_nxt     = press_begin ? (!first_latched_r && !startup_over_nxt) : long_supp_r;
    first_in_prog_nxt = press_begin ? long_supp_nxt : first_in_prog_r;
    long_sent_nxt     = press_begin ? 1'b0 : long_sent_r;
    first_latched_nxt = first_latched_r;
    press_on_nxt      = press_on_r;
    event_nxt         = EV_NONE;

    // modulo 2^32 held time; zero on the beat that starts a press
    held = s1_now_r - press_start_nxt;

    if (s1_pressed_r) begin
      press_on_nxt = 1'b1;
      // first press event wins over a long event on the same beat
      if (first_in_prog_nxt && (held >= first_hold_r)) begin
        first_latched_nxt = 1'b1;
        first_in_prog_nxt = 1'b0;
        event_nxt         = EV_FIRST;
      end else if (!long_supp_nxt && !long_sent_nxt && (held >= long_press_r)) begin
        long_sent_nxt = 1'b1;
        event_nxt     = EV_LONG;
      end
    end else if (press_on_r) begin
      // release: the first press never reports here
      press_on_nxt      = 1'b0;
      first_in_prog_nxt = 1'b0;
      if (!long_supp_nxt && !long_sent_nxt && (held >= first_hold_r)) begin
        event_nxt = (held >= long_press_r) ? EV_LONG : EV_SHORT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      startup_window_r <= STARTUP_WINDOW_RST;
      first_hold_r     <= FIRST_HOLD_RST;
      long_press_r     <= LONG_PRESS_RST;
      s1_valid_r       <= 1'b0;
      startup_over_r   <= 1'b0;
      first_latched_r  <= 1'b0;
      first_in_prog_r  <= 1'b0;
      press_on_r       <= 1'b0;
      press_start_r    <= '0;
      long_supp_r      <= 1'b0;
      long_sent_r      <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      // register writes; an index past the list is dropped
      if (cfg_we) begin
        case (cfg_idx)
          CFG_STARTUP_WINDOW: startup_window_r <= cfg_wdata;
          CFG_FIRST_HOLD:     first_hold_r     <= cfg_wdata;
          CFG_LONG_PRESS:     long_press_r     <= cfg_wdata;
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end

      if (advance) begin
        startup_over_r  <= startup_over_nxt;
        first_latched_r <= first_latched_nxt;
        first_in_prog_r <= first_in_prog_nxt;
        press_on_r      <= press_on_nxt;
        press_start_r   <= press_start_nxt;
        long_supp_r     <= long_supp_nxt;
        long_sent_r     <= long_sent_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_pressed_r <= in_ch.pressed;
      s1_now_r     <= in_ch.now_ms;
    end
    if (advance) begin
      out_event_r   <= event_nxt;
      out_latch_r   <= first_latched_nxt;
      out_startup_r <= startup_over_nxt;
      out_pending_r <= first_in_prog_nxt;
    end
  end

endmodule

// ===== design/spc_checker.sv =====
// port-level checker for the switch press classifier, with its bind
`timescale 1ns / 1ps
`include "switch_press_classifier_assert.svh"

module spc_checker
  import spc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input event_code_t out_event_res,
  input logic        out_hold_latch,
  input logic        out_startup_done,
  input logic        out_first_pending
);

  // a stalled result beat keeps its event, hold latch and startup flag
  `SPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_event_res) && $stable(out_hold_latch) &&
                   $stable(out_startup_done))

  // the first press latch never drops once shown
  `SPC_ASSERT_NEXT(a_latch_sticky, out_valid && out_hold_latch, !out_valid || out_hold_latch)

  // a pending first press means nothing has latched yet
  `SPC_ASSERT_NOW(a_pending_unlatched, out_valid && out_first_pending, !out_hold_latch)

  // first press event closes the pending press and sets the latch
  `SPC_ASSERT_NOW(a_first_ev, out_valid && (out_event_res == EV_FIRST),
                  out_hold_latch && !out_first_pending)

  // long and short events never come from the first press
  `SPC_ASSERT_NOW(a_no_ls_pending,
                  out_valid && ((out_event_res == EV_LONG) || (out_event_res == EV_SHORT)),
                  !out_first_pending)

endmodule

bind switch_press_classifier spc_checker u_spc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_event_res     (out_ch.event_res),
  .out_hold_latch    (out_ch.hold_latch),
  .out_startup_done  (out_ch.startup_done),
  .out_first_pending (out_ch.first_pending)
);

// ===== bench/tb.sv =====
// self-checking bench for the switch press classifier: directed script, then random phases
`timescale 1ns / 1ps

module tb;
  import spc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 6;
  localparam int PHASE_BEATS = 88;

  // one result beat as the classifier reports it
  typedef struct packed {
    event_code_t ev;
    logic        latch;
    logic        done;
    logic        pending;
  } press_result_t;

  // directed script: either a tick beat or a register write between beats
  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    logic          pressed;
    time_ms_t      value;     // now_ms for a tick, write data for a register
    cfg_idx_t      idx;
    logic          typed;     // expected result written into the row
    press_result_t want;
  } script_row_t;

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_idx;
  time_ms_t cfg_wdata;

  spc_in_if  in_bus ();
  spc_out_if out_bus ();

  switch_press_classifier DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // shadow copy of the registers, updated as they are written
  time_ms_t win_ms  = STARTUP_WINDOW_RST;
  time_ms_t hold_ms = FIRST_HOLD_RST;
  time_ms_t long_ms = LONG_PRESS_RST;

  // shadow copy of the press tracker
  logic     startup_over   = 1'b0;
  logic     first_latched  = 1'b0;
  logic     first_busy     = 1'b0;
  logic     press_on       = 1'b0;
  time_ms_t press_start    = '0;
  logic     long_blocked   = 1'b0;
  logic     long_sent      = 1'b0;

  press_result_t events_due[$];   // results owed by the block, oldest first
  int            mismatch_count = 0;
  int            results_seen   = 0;
  int            cycle_count    = 0;
  int            burst_left     = 0;

  // free-running clock, 10 ns period
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one tick of the press tracker: updates the shadow state, returns the beat
  function automatic press_result_t classify_tick(logic pressed, time_ms_t now);
    press_result_t r;
    time_ms_t      held;
    event_code_t   ev;
    ev = EV_NONE;
    // plain unsigned compare, sticky once set, so a wrap never reopens it
    if (!startup_over && now >= win_ms) startup_over = 1'b1;
    if (pressed && !press_on) begin
      press_on     = 1'b1;
      press_start  = now;
      long_sent    = 1'b0;
      // a press in the startup window with no first latch yet is the special first press
      long_blocked = !first_latched && !startup_over;
      first_busy   = long_blocked;
    end
    if (pressed) begin
      // thresholds are checked on the starting tick too, with zero held time
      held = now - press_start;
      if (first_busy && held >= hold_ms) begin
        first_latched = 1'b1;
        first_busy    = 1'b0;
        ev            = EV_FIRST;
      end else if (!long_blocked && !long_sent && held >= long_ms) begin
        long_sent = 1'b1;
        ev        = EV_LONG;
      end
    end else if (press_on) begin
      press_on   = 1'b0;
      held       = now - press_start;
      first_busy = 1'b0;
      // release of the first press never gives an event
      if (!long_blocked && !long_sent && held >= hold_ms)
        ev = (held >= long_ms) ? EV_LONG : EV_SHORT;
    end
    r.ev      = ev;
    r.latch   = first_latched;
    r.done    = startup_over;
    r.pending = first_busy;
    return r;
  endfunction

  function automatic script_row_t beat_row(logic p, time_ms_t t);
    script_row_t r;
    r         = '0;
    r.kind    = ROW_TICK;
    r.pressed = p;
    r.value   = t;
    return r;
  endfunction

  function automatic script_row_t checked_row(logic p, time_ms_t t, event_code_t ev,
                                              logic latch, logic done, logic pend);
    script_row_t r;
    r         = beat_row(p, t);
    r.typed   = 1'b1;
    r.want    = '{ev: ev, latch: latch, done: done, pending: pend};
    return r;
  endfunction

  function automatic script_row_t write_row(cfg_idx_t idx, time_ms_t v);
    script_row_t r;
    r       = '0;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.value = v;
    return r;
  endfunction

  // mostly small thresholds, with both extremes now and then
  function automatic time_ms_t pick_threshold(int unsigned span);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return time_ms_t'($urandom_range(0, span));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want_v);
    if (mismatch_count < 40)
      $display("mismatch on result %0d, %s: got %0d want %0d",
               results_seen, what, got, want_v);
    mismatch_count++;
  endtask

  // sends one tick beat; called and returns just after a falling edge
  task automatic send_tick(input logic p, input time_ms_t t, input logic typed,
                           input press_result_t want);
    press_result_t guess;
    int            gap;
    // sender works in bursts; a quarter of the bursts follow with no gap at all
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      repeat (gap) begin
        in_bus.valid <= 1'b0;
        @(negedge clk);
      end
    end
    burst_left--;
    in_bus.valid   <= 1'b1;
    in_bus.pressed <= p;
    in_bus.now_ms  <= t;
    do @(posedge clk); while (!in_bus.ready);
    // beat taken at this edge: advance the shadow tracker in step
    guess = classify_tick(p, t);
    events_due.push_back(typed ? want : guess);
    @(negedge clk);
  endtask

  // register write, only with the block drained; called just after a falling edge
  task automatic write_reg(input cfg_idx_t idx, input time_ms_t v);
    in_bus.valid <= 1'b0;
    while (events_due.size() != 0) @(negedge clk);
    // two-stage pipe, give it a little more than its depth
    repeat (3) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_STARTUP_WINDOW: win_ms  = v;
      CFG_FIRST_HOLD:     hold_ms = v;
      CFG_LONG_PRESS:     long_ms = v;
      default: ;
    endcase
  endtask

  // receiver: ready runs and stalls of random length, sometimes long free runs
  initial begin
    int ready_run;
    int stall_run;
    ready_run = 0;
    stall_run = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall_run > 0) begin
        out_bus.ready <= 1'b0;
        stall_run--;
      end else if (ready_run > 0) begin
        out_bus.ready <= 1'b1;
        ready_run--;
      end else begin
        ready_run = ($urandom_range(0, 5) == 0) ? 30 : $urandom_range(1, 12);
        stall_run = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        out_bus.ready <= (stall_run == 0);
        if (stall_run > 0) stall_run--;
        else ready_run--;
      end
    end
  end

  // result checker: every result beat against the oldest one owed
  always @(posedge clk) begin
    press_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (events_due.size() == 0) begin
        report_mismatch("result with nothing due", 32'(out_bus.event_res), 32'd0);
      end else begin
        want = events_due.pop_front();
        if (out_bus.event_res !== want.ev)
          report_mismatch("event_res", 32'(out_bus.event_res), 32'(want.ev));
        if (out_bus.hold_latch !== want.latch)
          report_mismatch("hold_latch", 32'(out_bus.hold_latch), 32'(want.latch));
        if (out_bus.startup_done !== want.done)
          report_mismatch("startup_done", 32'(out_bus.startup_done), 32'(want.done));
        if (out_bus.first_pending !== want.pending)
          report_mismatch("first_pending", 32'(out_bus.first_pending), 32'(want.pending));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    script_row_t script[$];
    logic        level;
    logic        p;
    int          run_left;
    time_ms_t    clock_ms;

    in_bus.valid   <= 1'b0;
    in_bus.pressed <= 1'b0;
    in_bus.now_ms  <= '0;
    cfg_we         <= 1'b0;
    cfg_idx        <= CFG_STARTUP_WINDOW;
    cfg_wdata      <= '0;
    rst_n          <= 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // reset registers: window 2000, first hold 50, long 1000
    // idle tick right after reset
    script.push_back(checked_row(1'b0, 32'd0,    EV_NONE,  1'b0, 1'b0, 1'b0));
    // first press released too early: pending clears, no event
    script.push_back(checked_row(1'b1, 32'd100,  EV_NONE,  1'b0, 1'b0, 1'b1));
    script.push_back(checked_row(1'b0, 32'd120,  EV_NONE,  1'b0, 1'b0, 1'b0));
    // first press held to exactly the hold time latches
    script.push_back(checked_row(1'b1, 32'd200,  EV_NONE,  1'b0, 1'b0, 1'b1));
    script.push_back(checked_row(1'b1, 32'd250,  EV_FIRST, 1'b1, 1'b0, 1'b0));
    // same press held past the long time: long stays suppressed, also on release
    script.push_back(checked_row(1'b1, 32'd1900, EV_NONE,  1'b1, 1'b0, 1'b0));
    script.push_back(checked_row(1'b0, 32'd1950, EV_NONE,  1'b1, 1'b0, 1'b0));
    // startup window ends exactly at its timestamp
    script.push_back(checked_row(1'b1, 32'd2000, EV_NONE,  1'b1, 1'b1, 1'b0));
    script.push_back(checked_row(1'b1, 32'd3000, EV_LONG,  1'b1, 1'b1, 1'b0));
    script.push_back(checked_row(1'b0, 32'd3500, EV_NONE,  1'b1, 1'b1, 1'b0));
    // one under the minimum hold gives nothing, the minimum gives short
    script.push_back(beat_row(1'b1, 32'd4000));
    script.push_back(checked_row(1'b0, 32'd4049, EV_NONE,  1'b1, 1'b1, 1'b0));
    script.push_back(beat_row(1'b1, 32'd5000));
    script.push_back(checked_row(1'b0, 32'd5050, EV_SHORT, 1'b1, 1'b1, 1'b0));
    // long reached only at release: long event on release
    script.push_back(beat_row(1'b1, 32'd7000));
    script.push_back(checked_row(1'b1, 32'd7999, EV_NONE,  1'b1, 1'b1, 1'b0));
    script.push_back(checked_row(1'b0, 32'd8000, EV_LONG,  1'b1, 1'b1, 1'b0));
    // held time across the timestamp wrap
    script.push_back(beat_row(1'b1, 32'hFFFF_FF00));
    script.push_back(checked_row(1'b0, 32'h0000_0100, EV_SHORT, 1'b1, 1'b1, 1'b0));
    // zero thresholds fire on the very tick the press starts
    script.push_back(write_row(CFG_FIRST_HOLD, 32'd0));
    script.push_back(write_row(CFG_LONG_PRESS, 32'd0));
    script.push_back(checked_row(1'b1, 32'hFFFF_FFFF, EV_LONG, 1'b1, 1'b1, 1'b0));
    script.push_back(checked_row(1'b0, 32'd0,   EV_NONE,  1'b1, 1'b1, 1'b0));
    // all-ones thresholds and window; a full-range hold still meets them
    script.push_back(write_row(CFG_FIRST_HOLD, 32'hFFFF_FFFF));
    script.push_back(write_row(CFG_LONG_PRESS, 32'hFFFF_FFFF));
    script.push_back(write_row(CFG_STARTUP_WINDOW, 32'hFFFF_FFFF));
    script.push_back(beat_row(1'b1, 32'd1));
    script.push_back(checked_row(1'b0, 32'd0,   EV_LONG,  1'b1, 1'b1, 1'b0));
    // threshold lowered while a press is held takes effect on the next tick
    script.push_back(write_row(CFG_FIRST_HOLD, 32'd50));
    script.push_back(beat_row(1'b1, 32'd10));
    script.push_back(write_row(CFG_LONG_PRESS, 32'd5));
    script.push_back(checked_row(1'b1, 32'd20,  EV_LONG,  1'b1, 1'b1, 1'b0));
    script.push_back(checked_row(1'b0, 32'd30,  EV_NONE,  1'b1, 1'b1, 1'b0));
    script.push_back(write_row(CFG_STARTUP_WINDOW, 32'd0));

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE)
        write_reg(script[i].idx, script[i].value);
      else
        send_tick(script[i].pressed, script[i].value, script[i].typed, script[i].want);
    end

    // random phases: new thresholds each phase, then press/release runs with
    // random timing; a few beats carry a random level as switch bounce
    level    = 1'b0;
    run_left = 0;
    clock_ms = $urandom;
    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(CFG_STARTUP_WINDOW, pick_threshold(4000));
      write_reg(CFG_FIRST_HOLD, pick_threshold(120));
      write_reg(CFG_LONG_PRESS, pick_threshold(600));
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (run_left == 0) begin
          level    = !level;
          run_left = level ? $urandom_range(1, 10) : $urandom_range(1, 4);
        end
        run_left--;
        p = ($urandom_range(0, 11) == 0) ? 1'($urandom_range(0, 1)) : level;
        case ($urandom_range(0, 24))
          0:       clock_ms = $urandom;
          1, 2, 3: clock_ms += $urandom_range(0, 3000);
          default: clock_ms += $urandom_range(0, 200);
        endcase
        send_tick(p, clock_ms, 1'b0, '0);
      end
    end

    in_bus.valid <= 1'b0;
    while (events_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
